// ----- rtl/ptrs_pkg.sv -----
`timescale 1ns / 1ps

package ptrs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_ADD      = 2'd1;
    localparam logic [1:0] CMD_DISPATCH = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic [7:0] PEND_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] countdown;
        logic [15:0] reload_period;
        logic [7:0]  pending_releases;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } tbl_wr_t;

    // slot index reported modulo 16
    function automatic logic [3:0] slot_field(input logic [IDX_W-1:0] idx);
        logic [63:0] wide;
        wide = 64'(idx);
        return wide[3:0];
    endfunction

endpackage

// ----- rtl/ptrs_if.sv -----
`timescale 1ns / 1ps

interface ptrs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] period;
    logic [15:0] first_delay;

    modport source (output valid, command, period, first_delay, input ready);
    modport sink   (input valid, command, period, first_delay, output ready);
endinterface

interface ptrs_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] dispatched_task;

    modport source (output valid, status, dispatched_task, input ready);
    modport sink   (input valid, status, dispatched_task, output ready);
endinterface

// ----- rtl/ptrs_table.sv -----
`timescale 1ns / 1ps

module ptrs_table (
    input  logic                        clk,
    input  ptrs_pkg::tbl_wr_t           wr,
    input  logic [ptrs_pkg::IDX_W-1:0]  rd_addr,
    output ptrs_pkg::entry_t            rd_data
);

    ptrs_pkg::entry_t mem [ptrs_pkg::MAX_TASKS];
    ptrs_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ptrs_alu.sv -----
`timescale 1ns / 1ps

module ptrs_alu (
    input  logic              dispatch,
    input  ptrs_pkg::entry_t  ent,
    output ptrs_pkg::entry_t  res,
    output logic              hit
);

    always_comb
    begin
        res = ent;
        hit = (ent.pending_releases != 8'd0);
        if (dispatch)
        begin
            if (hit)
            begin
                res.pending_releases = ent.pending_releases - 8'd1;
            end
        end
        else if (ent.countdown == 16'd0)
        begin
            if (ent.pending_releases != ptrs_pkg::PEND_MAX)
            begin
                res.pending_releases = ent.pending_releases + 8'd1;
            end
            res.countdown = ent.reload_period;
        end
        else
        begin
            res.countdown = ent.countdown - 16'd1;
        end
    end

endmodule

// ----- rtl/ptrs_seq.sv -----
`timescale 1ns / 1ps

module ptrs_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    ptrs_req_if.sink                    req,
    ptrs_rsp_if.source                  rsp,
    output ptrs_pkg::tbl_wr_t           wr,
    output logic [ptrs_pkg::IDX_W-1:0]  rd_addr,
    input  ptrs_pkg::entry_t            rd_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [ptrs_pkg::CNT_W-1:0]    tc_reg, tc_next;
    logic [ptrs_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                          disp_reg, disp_next;
    logic [1:0]                    res_status_reg, res_status_next;
    logic [ptrs_pkg::IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    out_status_reg, out_status_next;
    logic [3:0]                    out_task_reg, out_task_next;

    ptrs_pkg::entry_t              alu_res;
    logic                          alu_hit;
    logic                          transfer;
    logic                          idx_last;

    ptrs_alu u_alu (
        .dispatch (disp_reg),
        .ent      (rd_data),
        .res      (alu_res),
        .hit      (alu_hit)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign transfer  = req.valid && req.ready;
    assign idx_last  = ((ptrs_pkg::CNT_W'(idx_reg) + ptrs_pkg::CNT_W'(1)) == tc_reg);
    assign rd_addr   = (state_reg == S_SCAN) ? (idx_reg + ptrs_pkg::IDX_W'(1)) : '0;

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.dispatched_task = out_task_reg;

    always_comb
    begin
        state_next      = state_reg;
        tc_next         = tc_reg;
        idx_next        = idx_reg;
        disp_next       = disp_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_task_next   = out_task_reg;
        wr              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (transfer)
                begin
                    idx_next        = '0;
                    res_status_next = ptrs_pkg::ST_OK;
                    res_slot_next   = '0;
                    state_next      = S_DONE;
                    case (req.command)
                        ptrs_pkg::CMD_TICK:
                        begin
                            disp_next = 1'b0;
                            if (tc_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ptrs_pkg::CMD_ADD:
                        begin
                            if (tc_reg < ptrs_pkg::CNT_W'(ptrs_pkg::MAX_TASKS))
                            begin
                                wr.en                    = 1'b1;
                                wr.addr                  = tc_reg[ptrs_pkg::IDX_W-1:0];
                                wr.data.countdown        = req.first_delay;
                                wr.data.reload_period    = req.period;
                                wr.data.pending_releases = 8'd0;
                                res_slot_next            = tc_reg[ptrs_pkg::IDX_W-1:0];
                                tc_next                  = tc_reg + ptrs_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = ptrs_pkg::ST_FULL;
                            end
                        end
                        ptrs_pkg::CMD_DISPATCH:
                        begin
                            disp_next = 1'b1;
                            if (tc_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                res_status_next = ptrs_pkg::ST_NONE;
                            end
                        end
                        default:
                        begin
                            res_status_next = ptrs_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // rd_data holds the entry at idx_reg
                wr.addr = idx_reg;
                wr.data = alu_res;
                if (disp_reg)
                begin
                    if (alu_hit)
                    begin
                        wr.en         = 1'b1;
                        res_slot_next = idx_reg;
                        state_next    = S_DONE;
                    end
                    else if (idx_last)
                    begin
                        res_status_next = ptrs_pkg::ST_NONE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + ptrs_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    wr.en = 1'b1;
                    if (idx_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + ptrs_pkg::IDX_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_task_next   = ptrs_pkg::slot_field(res_slot_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tc_reg        <= tc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        disp_reg       <= disp_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_task_reg   <= out_task_next;
    end

endmodule

// ----- rtl/periodic_task_release_scheduler.sv -----
// Channel  Dir  Payload                              Transfer
// req      in   command, period, first_delay         valid && ready
// rsp      out  status, dispatched_task              valid && ready
//
// Tick and dispatch walk the task table one slot per cycle through the shared
// update unit. Add and unused commands skip the walk. req.ready is high only
// when idle. A finished result sits in the output register; a new command is
// taken while it waits, and the next result holds until rsp drains.
// Reset empties the table at once (task count to zero); no clearing pass.
`timescale 1ns / 1ps

module periodic_task_release_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    ptrs_req_if.sink    req,
    ptrs_rsp_if.source  rsp
);

    ptrs_pkg::tbl_wr_t                tbl_wr;
    logic [ptrs_pkg::IDX_W-1:0]       tbl_rd_addr;
    ptrs_pkg::entry_t                 tbl_rd_data;

    ptrs_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    ptrs_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .wr      (tbl_wr),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

endmodule

// ----- rtl/ptrs_checker.sv -----
`timescale 1ns / 1ps

module ptrs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_status,
    input logic [3:0] rsp_task
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_task))
        else $error("rsp payload changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req ready right after a transfer");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ptrs_pkg::ST_OK) || (rsp_status == ptrs_pkg::ST_FULL)
                      || (rsp_status == ptrs_pkg::ST_NONE))
        else $error("undefined status code");

    a_no_slot_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == ptrs_pkg::ST_FULL) || (rsp_status == ptrs_pkg::ST_NONE))
        |-> rsp_task == 4'd0)
        else $error("slot named on failed command");

endmodule

bind periodic_task_release_scheduler ptrs_checker u_ptrs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_task   (rsp.dispatched_task)
);
